>>> src/cdc_pkg.sv
`default_nettype none

package cdc_pkg;

  localparam int unsigned YearW  = 16;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;

  localparam logic [YearW-1:0]  YearMax    = '1;
  localparam logic [MonthW-1:0] MonthFirst = 4'd1;
  localparam logic [MonthW-1:0] MonthLast  = 4'd12;
  localparam logic [DayW-1:0]   DayFirst   = 5'd1;
  localparam logic [DayW-1:0]   DayLong    = 5'd31;
  localparam logic [DayW-1:0]   DayShort   = 5'd30;
  localparam logic [DayW-1:0]   DayFeb     = 5'd28;

  // y / 100 == (y * Div100Mul) >> Div100Shift for every 16-bit y
  localparam logic [16:0] Div100Mul   = 17'd83887;
  localparam int unsigned Div100Shift = 23;
  localparam int unsigned ProdW       = YearW + 17;
  localparam int unsigned QuotW       = ProdW - Div100Shift;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_NEXT = 2'd1,
    OP_PREV = 2'd2,
    OP_CMP  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_MONTH = 2'd1,
    ST_BAD_DAY   = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ORD_EQUAL   = 2'd0,
    ORD_EARLIER = 2'd1,
    ORD_LATER   = 2'd2,
    ORD_NONE    = 2'd3
  } order_e;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } date_t;

  typedef struct packed {
    date_t   date;
    status_e status;
    order_e  order;
  } result_t;

  function automatic logic leap_year(input logic [YearW-1:0] y);
    logic [ProdW-1:0] prod;
    logic [QuotW-1:0] quot;
    logic [YearW-1:0] hundreds;
    logic             div100;
    logic             div400;
    prod     = ProdW'(y) * ProdW'(Div100Mul);
    quot     = prod[ProdW-1:Div100Shift];
    hundreds = YearW'({quot, 6'b0}) + YearW'({quot, 5'b0}) + YearW'({quot, 2'b0});
    div100   = (hundreds == y);
    div400   = div100 && (quot[1:0] == 2'b00);
    return div100 ? div400 : (y[1:0] == 2'b00);
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    case (m)
      4'd2:                       len = DayFeb + DayW'(leap);
      4'd4, 4'd6, 4'd9, 4'd11:    len = DayShort;
      default:                    len = DayLong;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

>>> src/calendar_date_counter_unit.sv
// Gregorian date counter (year, month, day; 4/100/400 leap rule).
// Input channel: in_valid_i/in_ready_o carry one beat of opcode_i plus the
// argument date (load, next day, previous day, compare).
// Output channel: out_valid_o/out_ready_i carry one beat per input beat:
// held date after the item, status_o and order_o (compare only).
// The result is registered and presented in the cycle after the input beat is taken.
// Throughput: one beat per cycle while results are taken; the held date is
// updated in the same edge that takes the beat, so the next beat sees it at once.
// The single result register sets the rate: in_ready_o is high whenever
// that register is empty or being drained in the same cycle.
// When the receiver stalls the result holds and in_ready_o drops until it
// is taken.
// Reset (rst_ni low, asynchronous) sets the date to 0000-01-01 and empties
// the result register.
// A rejected load or a step past the year range leaves the date unchanged.
`default_nettype none

module calendar_date_counter_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  opcode_i,
  input  logic [cdc_pkg::YearW-1:0]   arg_year_i,
  input  logic [cdc_pkg::MonthW-1:0]  arg_month_i,
  input  logic [cdc_pkg::DayW-1:0]    arg_day_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [cdc_pkg::YearW-1:0]   cur_year_o,
  output logic [cdc_pkg::MonthW-1:0]  cur_month_o,
  output logic [cdc_pkg::DayW-1:0]    cur_day_o,
  output logic [1:0]                  status_o,
  output logic [1:0]                  order_o
);
  import cdc_pkg::*;

  date_t   held_q;
  date_t   arg;
  result_t step_res;
  result_t res_q;
  logic    out_valid_q;
  logic    in_beat;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_beat    = in_valid_i && in_ready_o;

  assign arg.year  = arg_year_i;
  assign arg.month = arg_month_i;
  assign arg.day   = arg_day_i;

  cdc_step u_step (
    .op_i   (opcode_e'(opcode_i)),
    .arg_i  (arg),
    .held_i (held_q),
    .res_o  (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q.year  <= '0;
      held_q.month <= MonthFirst;
      held_q.day   <= DayFirst;
      out_valid_q  <= 1'b0;
    end else if (in_beat) begin
      held_q      <= step_res.date;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      res_q <= step_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cur_year_o  = res_q.date.year;
  assign cur_month_o = res_q.date.month;
  assign cur_day_o   = res_q.date.day;
  assign status_o    = res_q.status;
  assign order_o     = res_q.order;

  a_beat_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> out_valid_o && (cur_year_o == held_q.year)
      && (cur_month_o == held_q.month) && (cur_day_o == held_q.day))
    else $error("result does not match held date after beat");

  a_held_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q.month >= MonthFirst && held_q.month <= MonthLast
      && held_q.day >= DayFirst && held_q.day <= DayLong)
    else $error("held date out of range");

  a_order_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && order_o != ORD_EQUAL |-> status_o == ST_OK)
    else $error("order reported with error status");

endmodule

`default_nettype wire

>>> src/cdc_step.sv
`default_nettype none

module cdc_step (
  input  cdc_pkg::opcode_e op_i,
  input  cdc_pkg::date_t   arg_i,
  input  cdc_pkg::date_t   held_i,
  output cdc_pkg::result_t res_o
);
  import cdc_pkg::*;

  logic            arg_leap;
  logic            held_leap;
  logic [DayW-1:0] arg_len;
  logic [DayW-1:0] held_len;
  logic [DayW-1:0] prev_len;

  assign arg_leap  = leap_year(arg_i.year);
  assign held_leap = leap_year(held_i.year);
  assign arg_len   = month_len(arg_i.month, arg_leap);
  assign held_len  = month_len(held_i.month, held_leap);
  assign prev_len  = month_len(held_i.month - MonthW'(1), held_leap);

  always_comb begin
    res_o.date   = held_i;
    res_o.status = ST_OK;
    res_o.order  = ORD_EQUAL;
    case (op_i)
      OP_LOAD: begin
        if (!(arg_i.month inside {[MonthFirst:MonthLast]})) begin
          res_o.status = ST_BAD_MONTH;
        end else if (arg_i.day == '0 || arg_i.day > arg_len) begin
          res_o.status = ST_BAD_DAY;
        end else begin
          res_o.date = arg_i;
        end
      end
      OP_NEXT: begin
        if (held_i.day < held_len) begin
          res_o.date.day = held_i.day + DayW'(1);
        end else if (held_i.month < MonthLast) begin
          res_o.date.month = held_i.month + MonthW'(1);
          res_o.date.day   = DayFirst;
        end else if (held_i.year == YearMax) begin
          res_o.status = ST_RANGE;
        end else begin
          res_o.date.year  = held_i.year + YearW'(1);
          res_o.date.month = MonthFirst;
          res_o.date.day   = DayFirst;
        end
      end
      OP_PREV: begin
        if (held_i.day > DayFirst) begin
          res_o.date.day = held_i.day - DayW'(1);
        end else if (held_i.month > MonthFirst) begin
          res_o.date.month = held_i.month - MonthW'(1);
          res_o.date.day   = prev_len;
        end else if (held_i.year == '0) begin
          res_o.status = ST_RANGE;
        end else begin
          res_o.date.year  = held_i.year - YearW'(1);
          res_o.date.month = MonthLast;
          res_o.date.day   = DayLong;
        end
      end
      OP_CMP: begin
        if (held_i < arg_i) begin
          res_o.order = ORD_EARLIER;
        end else if (held_i > arg_i) begin
          res_o.order = ORD_LATER;
        end else begin
          res_o.order = ORD_EQUAL;
        end
      end
      default: begin
        res_o.status = ST_OK;
      end
    endcase
  end

endmodule

`default_nettype wire
